// File: src/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/dnsqp_pkg.sv
// types and constants of the dns query parser
package dnsqp_pkg;

    localparam int FifoDepthDefault = 4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_LABEL  = 3'd2,
        PH_TAIL   = 3'd3,
        PH_DONE   = 3'd4,
        PH_DRAIN  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_CHAR     = 2'd0,
        KIND_HEADER   = 2'd1,
        KIND_QUESTION = 2'd2,
        KIND_ERROR    = 2'd3
    } t_kind;

    localparam logic ERR_FORMAT   = 1'b0;
    localparam logic ERR_NOT_IMPL = 1'b1;

    // header byte positions
    localparam logic [3:0] HDR_ID_HI    = 4'd0;
    localparam logic [3:0] HDR_ID_LO    = 4'd1;
    localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
    localparam logic [3:0] HDR_QD_HI    = 4'd4;
    localparam logic [3:0] HDR_QD_LO    = 4'd5;
    localparam logic [3:0] HDR_LAST_IDX = 4'd11;

    localparam logic [1:0] TAIL_LAST_IDX = 2'd3;
    localparam logic [8:0] NAME_LIMIT    = 9'd255;
    localparam logic [7:0] DOT_CHAR      = 8'h2E;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  name_char;
        logic [15:0] query_id;
        logic        recursion_desired;
        logic [15:0] question_total;
        logic [15:0] query_type;
        logic [15:0] query_class;
        logic        error_code;
        logic        last_of_run;
    } t_result;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

// File: src/dnsqp_channels.sv
// valid/ready channel interfaces of the dns query parser
interface dnsqp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsqp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] query_id;
    logic        recursion_desired;
    logic [15:0] question_total;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic        error_code;
    logic        last_of_run;

    modport source (
        output valid, output kind, output name_char, output query_id,
        output recursion_desired, output question_total, output query_type,
        output query_class, output error_code, output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input name_char, input query_id,
        input recursion_desired, input question_total, input query_type,
        input query_class, input error_code, input last_of_run, output ready
    );
endinterface

// File: src/dnsqp_parser.sv
// per-byte parse state and result generation
module dnsqp_parser
    import dnsqp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output t_push      o_push
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_header_index, n_header_index;
    logic [15:0] r_message_id, n_message_id;
    logic        r_rd_flag, n_rd_flag;
    logic [15:0] r_questions_left, n_questions_left;
    logic [5:0]  r_label_left, n_label_left;
    logic [7:0]  r_name_length, n_name_length;
    logic        r_first_label, n_first_label;
    logic [1:0]  r_tail_index, n_tail_index;
    logic [23:0] r_type_class_shift, n_type_class_shift;

    t_phase      step_phase;
    logic        e0_valid;
    t_kind       e0_kind;
    logic [7:0]  e0_char;
    logic [15:0] e0_qtot;
    logic [15:0] e0_qt;
    logic [15:0] e0_qc;
    logic        e0_ec;
    logic [15:0] res_id;
    logic        res_rd;
    logic        late_fail;
    logic [8:0]  name_total;
    logic [31:0] tail_word;
    t_result     res_main;
    t_result     res_late;

    assign name_total = {1'b0, r_name_length} + 9'd1 + {3'b000, i_data_byte[5:0]};
    assign tail_word  = {r_type_class_shift, i_data_byte};

    // next state
    always_comb begin
        n_phase            = r_phase;
        n_header_index     = r_header_index;
        n_message_id       = r_message_id;
        n_rd_flag          = r_rd_flag;
        n_questions_left   = r_questions_left;
        n_label_left       = r_label_left;
        n_name_length      = r_name_length;
        n_first_label      = r_first_label;
        n_tail_index       = r_tail_index;
        n_type_class_shift = r_type_class_shift;

        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    n_header_index = r_header_index + 4'd1;
                    case (r_header_index)
                        HDR_ID_HI: n_message_id = {i_data_byte, r_message_id[7:0]};
                        HDR_ID_LO: n_message_id = {r_message_id[15:8], i_data_byte};
                        HDR_FLAGS_HI: begin
                            n_rd_flag = i_data_byte[0];
                            // qr, opcode, aa or tc set
                            if (i_data_byte[7:1] != 7'd0) begin
                                n_phase = PH_DRAIN;
                            end
                        end
                        HDR_FLAGS_LO: begin
                            if (i_data_byte[7]) begin
                                n_phase = PH_DRAIN;
                            end
                        end
                        HDR_QD_HI: n_questions_left = {i_data_byte, r_questions_left[7:0]};
                        HDR_QD_LO: n_questions_left = {r_questions_left[15:8], i_data_byte};
                        default: begin
                            if (r_header_index inside {[HDR_LAST_IDX:4'd15]}) begin
                                n_phase       = (r_questions_left != 16'd0) ? PH_LEN : PH_DONE;
                                n_first_label = 1'b1;
                                n_name_length = '0;
                            end
                        end
                    endcase
                end
                PH_LEN: begin
                    if (i_data_byte == 8'd0) begin
                        // end of name, four tail bytes follow
                        n_phase            = PH_TAIL;
                        n_tail_index       = '0;
                        n_type_class_shift = '0;
                    end else if (i_data_byte[7:6] != 2'b00 || name_total >= NAME_LIMIT) begin
                        n_phase = PH_DRAIN;
                    end else begin
                        n_first_label = 1'b0;
                        n_name_length = name_total[7:0];
                        n_label_left  = i_data_byte[5:0];
                        n_phase       = PH_LABEL;
                    end
                end
                PH_LABEL: begin
                    n_label_left = r_label_left - 6'd1;
                    if (r_label_left == 6'd1) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_TAIL: begin
                    n_type_class_shift = tail_word[23:0];
                    if (r_tail_index == TAIL_LAST_IDX) begin
                        n_questions_left = r_questions_left - 16'd1;
                        n_tail_index     = '0;
                        n_first_label    = 1'b1;
                        n_name_length    = '0;
                        n_phase = (r_questions_left != 16'd1) ? PH_LEN : PH_DONE;
                    end else begin
                        n_tail_index = r_tail_index + 2'd1;
                    end
                end
                default: ;
            endcase
        end

        // phase reached by this byte, before the packet restart
        step_phase = n_phase;

        // every packet starts from a clean state
        if (i_valid && i_last_byte) begin
            n_phase            = PH_HEADER;
            n_header_index     = '0;
            n_message_id       = '0;
            n_rd_flag          = 1'b0;
            n_questions_left   = '0;
            n_label_left       = '0;
            n_name_length      = '0;
            n_first_label      = 1'b1;
            n_tail_index       = '0;
            n_type_class_shift = '0;
        end
    end

    // results of the accepted byte
    always_comb begin
        e0_valid = 1'b0;
        e0_kind  = KIND_CHAR;
        e0_char  = '0;
        e0_qtot  = '0;
        e0_qt    = '0;
        e0_qc    = '0;
        e0_ec    = ERR_FORMAT;
        res_id   = r_message_id;
        res_rd   = r_rd_flag;

        if (i_valid) begin
            case (r_phase)
                PH_HEADER: begin
                    case (r_header_index)
                        HDR_ID_HI: res_id = {i_data_byte, r_message_id[7:0]};
                        HDR_ID_LO: res_id = {r_message_id[15:8], i_data_byte};
                        HDR_FLAGS_HI: begin
                            res_rd = i_data_byte[0];
                            if (i_data_byte[7:1] != 7'd0) begin
                                e0_valid = 1'b1;
                                e0_kind  = KIND_ERROR;
                                // qr wins over the opcode, the opcode over aa and tc
                                e0_ec    = (!i_data_byte[7] && i_data_byte[6:3] != 4'd0) ?
                                           ERR_NOT_IMPL : ERR_FORMAT;
                            end
                        end
                        HDR_FLAGS_LO: begin
                            if (i_data_byte[7]) begin
                                e0_valid = 1'b1;
                                e0_kind  = KIND_ERROR;
                                e0_ec    = ERR_FORMAT;
                            end
                        end
                        default: begin
                            if (r_header_index inside {[HDR_LAST_IDX:4'd15]}) begin
                                e0_valid = 1'b1;
                                e0_kind  = KIND_HEADER;
                                e0_qtot  = r_questions_left;
                            end
                        end
                    endcase
                end
                PH_LEN: begin
                    if (i_data_byte != 8'd0) begin
                        if (i_data_byte[7:6] != 2'b00 || name_total >= NAME_LIMIT) begin
                            e0_valid = 1'b1;
                            e0_kind  = KIND_ERROR;
                            e0_ec    = ERR_FORMAT;
                        end else if (!r_first_label) begin
                            e0_valid = 1'b1;
                            e0_kind  = KIND_CHAR;
                            e0_char  = DOT_CHAR;
                        end
                    end
                end
                PH_LABEL: begin
                    e0_valid = 1'b1;
                    e0_kind  = KIND_CHAR;
                    e0_char  = i_data_byte;
                end
                PH_TAIL: begin
                    if (r_tail_index == TAIL_LAST_IDX) begin
                        e0_valid = 1'b1;
                        e0_kind  = KIND_QUESTION;
                        e0_qt    = tail_word[31:16];
                        e0_qc    = tail_word[15:0];
                    end
                end
                default: ;
            endcase
        end

        // packet ends before the message is complete
        late_fail = i_valid && i_last_byte &&
                    (step_phase inside {PH_HEADER, PH_LEN, PH_LABEL, PH_TAIL});

        res_main.kind              = e0_kind;
        res_main.name_char         = e0_char;
        res_main.query_id          = res_id;
        res_main.recursion_desired = res_rd;
        res_main.question_total    = e0_qtot;
        res_main.query_type        = e0_qt;
        res_main.query_class       = e0_qc;
        res_main.error_code        = e0_ec;
        res_main.last_of_run       = !late_fail;

        res_late.kind              = KIND_ERROR;
        res_late.name_char         = '0;
        res_late.query_id          = res_id;
        res_late.recursion_desired = res_rd;
        res_late.question_total    = '0;
        res_late.query_type        = '0;
        res_late.query_class       = '0;
        res_late.error_code        = ERR_FORMAT;
        res_late.last_of_run       = 1'b1;

        if (e0_valid) begin
            o_push.count  = late_fail ? 2'd2 : 2'd1;
            o_push.first  = res_main;
            o_push.second = res_late;
        end else begin
            o_push.count  = late_fail ? 2'd1 : 2'd0;
            o_push.first  = res_late;
            o_push.second = res_late;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase            <= PH_HEADER;
            r_header_index     <= '0;
            r_message_id       <= '0;
            r_rd_flag          <= 1'b0;
            r_questions_left   <= '0;
            r_label_left       <= '0;
            r_name_length      <= '0;
            r_first_label      <= 1'b1;
            r_tail_index       <= '0;
            r_type_class_shift <= '0;
        end else begin
            r_phase            <= n_phase;
            r_header_index     <= n_header_index;
            r_message_id       <= n_message_id;
            r_rd_flag          <= n_rd_flag;
            r_questions_left   <= n_questions_left;
            r_label_left       <= n_label_left;
            r_name_length      <= n_name_length;
            r_first_label      <= n_first_label;
            r_tail_index       <= n_tail_index;
            r_type_class_shift <= n_type_class_shift;
        end
    end

endmodule

// File: src/dnsqp_result_fifo.sv
// result queue taking up to two entries per cycle, one out per transaction
module dnsqp_result_fifo
    import dnsqp_pkg::*;
#(
    parameter int DEPTH = FifoDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_room,
    dnsqp_out_if.source o_out
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrMax  = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] RoomMax = CntW'(DEPTH - 2);

    t_result        r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_level, n_level;
    logic [PtrW-1:0] wr_ptr_next;
    logic            pop;
    t_result         head;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        ptr_inc = (p == PtrMax) ? '0 : p + PtrW'(1);
    endfunction

    assign head        = r_mem[r_rd_ptr];
    assign pop         = o_out.valid && o_out.ready;
    assign wr_ptr_next = ptr_inc(r_wr_ptr);
    // room for the worst case of two results from one byte
    assign o_room      = (r_level <= RoomMax);

    always_comb begin
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        case (i_push.count)
            2'd1:    n_wr_ptr = wr_ptr_next;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr_next);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_level = r_level + CntW'(i_push.count) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    assign o_out.valid             = (r_level != '0);
    assign o_out.kind              = head.kind;
    assign o_out.name_char         = head.name_char;
    assign o_out.query_id          = head.query_id;
    assign o_out.recursion_desired = head.recursion_desired;
    assign o_out.question_total    = head.question_total;
    assign o_out.query_type        = head.query_type;
    assign o_out.query_class       = head.query_class;
    assign o_out.error_code        = head.error_code;
    assign o_out.last_of_run       = head.last_of_run;

endmodule

// File: src/dns_query_header_name_parser_top.sv
// top level of the dns query header and name parser
//
//  channel | dir | payload                                   | transaction
//  i_in    | in  | data_byte, last_byte                      | one message byte
//  o_out   | out | kind, name_char, query_id, rd, counts,    | one result
//          |     | query_type, query_class, error_code, last |
//
// one byte per clock while the queue has room: the parse state updates in the
// cycle a byte is taken and its results (zero, one, or two) land in the result
// queue at that edge, so a result is queued from the cycle after its byte
// input ready follows the queue alone: it is low only while fewer than two
// queue slots are free, so a stalled output holds back input after a few bytes
// reset is synchronous, active low; it returns the parse state to the header
// and empties the queue
// the final byte of each packet also returns the parse state to the header
module dns_query_header_name_parser_top
    import dnsqp_pkg::*;
#(
    parameter int FIFO_DEPTH = FifoDepthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dnsqp_in_if.sink    i_in,
    dnsqp_out_if.source o_out
);

`include "assert_macros.svh"

    t_push push;
    logic  room;
    logic  in_accept;
    logic  pushed_any;
    logic  pushed_one;
    logic  pushed_two;
    logic  pair_ok;

    // byte transaction completes when the queue can absorb its results
    assign i_in.ready = room;
    assign in_accept  = i_in.valid && room;

    // header checks, label decoding, qtype/qclass capture
    dnsqp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_accept),
        .i_data_byte (i_in.data_byte),
        .i_last_byte (i_in.last_byte),
        .o_push      (push)
    );

    // result queue decouples the output handshake from byte intake
    dnsqp_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

    assign pushed_any = (push.count != 2'd0);
    assign pushed_one = (push.count == 2'd1);
    assign pushed_two = (push.count == 2'd2);
    assign pair_ok    = (push.second.kind == KIND_ERROR) && push.second.last_of_run &&
                        !push.first.last_of_run;

    // results only come from an accepted byte
    `ASSERT_IMPLIES(a_push_only_on_accept, i_clk, i_rst_n, pushed_any, in_accept)
    // a second result is always the early-end format error closing the run
    `ASSERT_IMPLIES(a_pair_is_late_error, i_clk, i_rst_n, pushed_two, pair_ok)
    // a lone result always closes its run
    `ASSERT_IMPLIES(a_single_closes_run, i_clk, i_rst_n, pushed_one, push.first.last_of_run)
    // after any push the output holds a valid result on the next cycle
    `ASSERT_NEXT(a_output_after_push, i_clk, i_rst_n, pushed_any, o_out.valid)

endmodule

// File: dv/dnsqp_tb_pkg.sv
// scoreboard class holding the parse predictor of the dns query parser bench
package dnsqp_tb_pkg;
    import dnsqp_pkg::*;

    class dns_parse_predictor;
        t_phase      phase;
        logic [3:0]  hdr_idx;
        logic [15:0] msg_id;
        logic        rd;
        logic [15:0] qd_left;
        logic [5:0]  label_left;
        logic [7:0]  name_len;
        logic        first_label;
        logic [1:0]  tail_idx;
        logic [31:0] tc_shift;

        t_result     expected_results[$];
        t_result     step_results[$];
        int          failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            phase       = PH_HEADER;
            hdr_idx     = '0;
            msg_id      = '0;
            rd          = 1'b0;
            qd_left     = '0;
            label_left  = '0;
            name_len    = '0;
            first_label = 1'b1;
            tail_idx    = '0;
            tc_shift    = '0;
        endfunction

        function void add_result(t_kind kind, logic [7:0] ch, logic [15:0] qtot,
                                 logic [15:0] qt, logic [15:0] qc, logic ec);
            t_result r;
            r.kind              = kind;
            r.name_char         = ch;
            r.query_id          = msg_id;
            r.recursion_desired = rd;
            r.question_total    = qtot;
            r.query_type        = qt;
            r.query_class       = qc;
            r.error_code        = ec;
            r.last_of_run       = 1'b0;
            step_results.insert(step_results.size(), r);
        endfunction

        function void flag_error(logic ec);
            phase = PH_DRAIN;
            add_result(KIND_ERROR, '0, '0, '0, '0, ec);
        endfunction

        // one accepted byte: advance the parse state, queue what it produces
        function void take_byte(logic [7:0] b, logic last);
            logic [3:0] idx;
            logic [8:0] total;
            step_results.delete();
            case (phase)
                PH_HEADER: begin
                    idx     = hdr_idx;
                    hdr_idx = idx + 4'd1;
                    case (idx)
                        HDR_ID_HI: msg_id = {b, msg_id[7:0]};
                        HDR_ID_LO: msg_id = {msg_id[15:8], b};
                        HDR_FLAGS_HI: begin
                            rd = b[0];
                            if (b[7]) flag_error(ERR_FORMAT);
                            else if (b[6:3] != 4'd0) flag_error(ERR_NOT_IMPL);
                            else if (b[2] || b[1]) flag_error(ERR_FORMAT);
                        end
                        HDR_FLAGS_LO: begin
                            if (b[7]) flag_error(ERR_FORMAT);
                        end
                        HDR_QD_HI: qd_left = {b, qd_left[7:0]};
                        HDR_QD_LO: qd_left = {qd_left[15:8], b};
                        default: begin
                            if (idx >= HDR_LAST_IDX) begin
                                add_result(KIND_HEADER, '0, qd_left, '0, '0, 1'b0);
                                phase       = (qd_left != 16'd0) ? PH_LEN : PH_DONE;
                                first_label = 1'b1;
                                name_len    = '0;
                            end
                        end
                    endcase
                end
                PH_LEN: begin
                    if (b == 8'd0) begin
                        phase    = PH_TAIL;
                        tail_idx = '0;
                        tc_shift = '0;
                    end else if (b[7:6] != 2'b00) begin
                        flag_error(ERR_FORMAT);
                    end else begin
                        total = {1'b0, name_len} + 9'd1 + {3'b000, b[5:0]};
                        if (total >= NAME_LIMIT) begin
                            flag_error(ERR_FORMAT);
                        end else begin
                            if (!first_label) add_result(KIND_CHAR, DOT_CHAR, '0, '0, '0, 1'b0);
                            first_label = 1'b0;
                            name_len    = total[7:0];
                            label_left  = b[5:0];
                            phase       = PH_LABEL;
                        end
                    end
                end
                PH_LABEL: begin
                    add_result(KIND_CHAR, b, '0, '0, '0, 1'b0);
                    label_left = label_left - 6'd1;
                    if (label_left == 6'd0) phase = PH_LEN;
                end
                PH_TAIL: begin
                    tc_shift = {tc_shift[23:0], b};
                    if (tail_idx == TAIL_LAST_IDX) begin
                        add_result(KIND_QUESTION, '0, '0, tc_shift[31:16], tc_shift[15:0], 1'b0);
                        qd_left     = qd_left - 16'd1;
                        tail_idx    = '0;
                        first_label = 1'b1;
                        name_len    = '0;
                        phase       = (qd_left != 16'd0) ? PH_LEN : PH_DONE;
                    end else begin
                        tail_idx = tail_idx + 2'd1;
                    end
                end
                default: ;
            endcase
            if (last) begin
                if (phase inside {PH_HEADER, PH_LEN, PH_LABEL, PH_TAIL}) flag_error(ERR_FORMAT);
                clear();
            end
            if (step_results.size() > 0) step_results[step_results.size() - 1].last_of_run = 1'b1;
            foreach (step_results[i]) expected_results.insert(expected_results.size(),
                                                              step_results[i]);
        endfunction

        function void check_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                failures++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // one accepted result against the oldest expectation
        function void match_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result, expected none, actual kind %0d char %0h",
                         $time, got.kind, got.name_char);
                return;
            end
            want = expected_results.pop_front();
            check_field("kind", 16'(want.kind), 16'(got.kind));
            check_field("name_char", 16'(want.name_char), 16'(got.name_char));
            check_field("query_id", want.query_id, got.query_id);
            check_field("recursion_desired", 16'(want.recursion_desired),
                        16'(got.recursion_desired));
            check_field("question_total", want.question_total, got.question_total);
            check_field("query_type", want.query_type, got.query_type);
            check_field("query_class", want.query_class, got.query_class);
            check_field("error_code", 16'(want.error_code), 16'(got.error_code));
            check_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        endfunction
    endclass

endpackage

// File: dv/tb.sv
// top-level bench for the dns query header and name parser
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnsqp_pkg::*;
    import dnsqp_tb_pkg::*;

    // generous cycle budget, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // bytes sent over the whole run, directed part included
    localparam int BYTE_BUDGET = 900;
    localparam int IDLE_PCT    = 31;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dnsqp_in_if  in_ch ();
    dnsqp_out_if out_ch ();

    dns_query_header_name_parser_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dns_parse_predictor predictor = new();

    // bytes of the packet being built, sent as one run with last on the final byte
    logic [7:0] pkt[$];
    int         bytes_sent = 0;
    int         cycles = 0;
    int         hold_cycles = 0;   // receiver hold-off request, counted down by the receiver
    logic       steady = 1'b0;     // no idling on either side while set

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run-away guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result monitor: every accepted result transaction goes to the scoreboard
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind              = t_kind'(out_ch.kind);
            got.name_char         = out_ch.name_char;
            got.query_id          = out_ch.query_id;
            got.recursion_desired = out_ch.recursion_desired;
            got.question_total    = out_ch.question_total;
            got.query_type        = out_ch.query_type;
            got.query_class       = out_ch.query_class;
            got.error_code        = out_ch.error_code;
            got.last_of_run       = out_ch.last_of_run;
            predictor.match_result(got);
        end
    end

    // receiver: random back-pressure, or a long hold-off when one is requested
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                out_ch.ready = 1'b0;
                hold_cycles--;
            end else begin
                out_ch.ready = steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic put(logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endtask

    // 12-byte header; answer, authority and additional counts are random
    task automatic put_header(logic [15:0] id, logic [7:0] flags_hi, logic [7:0] flags_lo,
                              logic [15:0] qd);
        put(id[15:8]);
        put(id[7:0]);
        put(flags_hi);
        put(flags_lo);
        put(qd[15:8]);
        put(qd[7:0]);
        repeat (6) put(8'($urandom));
    endtask

    task automatic put_label(int len);
        put(8'(len));
        repeat (len) put(8'($urandom));
    endtask

    task automatic put_tail(logic [15:0] qt, logic [15:0] qc);
        put(qt[15:8]);
        put(qt[7:0]);
        put(qc[15:8]);
        put(qc[7:0]);
    endtask

    // offer one byte at the falling edge, hold it until the block takes it
    task automatic send_byte(logic [7:0] b, logic last);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = b;
        in_ch.last_byte = last;
        do @(posedge i_clk); while (!in_ch.ready);
        predictor.take_byte(b, last);
        bytes_sent++;
    endtask

    // keep = 0 sends the whole packet, otherwise at most its first keep bytes
    task automatic send_packet(int keep);
        int n;
        n = (keep > 0 && keep < pkt.size()) ? keep : pkt.size();
        for (int i = 0; i < n; i++) send_byte(pkt[i], i == n - 1);
        pkt.delete();
    endtask

    // sender pause: input idle until every expected result has come out
    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (predictor.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed queries with random content, some noise and broken ones
    task automatic build_random_packet();
        int unsigned shape;
        int unsigned nq;
        logic [7:0]  fh;
        logic [7:0]  fl;
        logic [15:0] qd;
        pkt.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 24)) put(8'($urandom));
            return;
        end
        fh = {7'd0, 1'($urandom)};
        if (shape < 16) fh = 8'($urandom);
        fl = {1'b0, 7'($urandom)};
        if (shape >= 16 && shape < 20) fl = 8'($urandom);
        qd = 16'($urandom_range(1, 3));
        if (shape >= 20 && shape < 25) qd = 16'd0;
        else if (shape >= 25 && shape < 28) qd = 16'($urandom);
        put_header(16'($urandom), fh, fl, qd);
        nq = (qd > 16'd4) ? 4 : 32'(qd);
        repeat (nq) begin
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 99) < 4) put(8'($urandom_range(64, 255)));
                else put_label(($urandom_range(0, 99) < 5) ? 63 : $urandom_range(1, 12));
            end
            put(8'h00);
            put_tail(16'($urandom), 16'($urandom));
        end
        repeat ($urandom_range(0, 4)) put(8'($urandom));
    endtask

    initial begin
        int         pkt_no;
        int         keep;
        logic [7:0] bad_len [3];
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        bad_len         = '{8'h40, 8'h80, 8'hC0};

        // synchronous reset, held low at the start, then released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---------------- directed part ----------------
        // extreme header fields, name bytes 00/ff, extreme type and class, trailing byte
        put_header(16'hFFFF, 8'h01, 8'h7F, 16'd1);
        put(8'd3); put(8'h00); put(8'hFF); put(DOT_CHAR); put(8'h00);
        put_tail(16'hFFFF, 16'hFFFF);
        put(8'hAA);
        send_packet(0);

        // header flag errors: qr, nonzero opcode, aa, tc, then ra
        put_header(16'h0000, 8'h80, 8'h00, 16'd1); send_packet(0);
        put_header(16'h1234, 8'h79, 8'h00, 16'd1); send_packet(0);
        put_header(16'h5A5A, 8'h04, 8'h00, 16'd1); send_packet(0);
        put_header(16'hA5A5, 8'h02, 8'h00, 16'd1); send_packet(0);
        put_header(16'h0F0F, 8'h00, 8'h80, 16'd1); send_packet(0);

        // zero questions: header done, the rest ignored
        put_header(16'h0001, 8'h01, 8'h00, 16'd0);
        put(8'h03); put(8'hC0); put(8'hFF);
        send_packet(0);

        // empty root name, packet ends on the last tail byte
        put_header(16'h0002, 8'h00, 8'h00, 16'd1);
        put(8'h00);
        put_tail(16'h0001, 16'h0001);
        send_packet(0);

        // label types with the top bits set
        foreach (bad_len[i]) begin
            put_header(16'h0003, 8'h00, 8'h00, 16'd1);
            put(bad_len[i]);
            send_packet(0);
        end

        // longest legal name (254) followed by one that reaches the limit,
        // the first sent as a long stretch with no idling on either side
        steady = 1'b1;
        put_header(16'h0004, 8'h01, 8'h00, 16'd1);
        repeat (3) put_label(63);
        put_label(61);
        put(8'h00);
        put_tail(16'h001C, 16'h00FF);
        send_packet(0);
        steady = 1'b0;
        put_header(16'h0005, 8'h01, 8'h00, 16'd1);
        repeat (3) put_label(63);
        put(8'd63);
        send_packet(0);

        // two questions, each parsed on its own, dots between labels
        put_header(16'h0006, 8'h00, 8'h00, 16'd2);
        put_label(1); put_label(2); put(8'h00); put_tail(16'h0005, 16'h0001);
        put_label(5); put(8'h00); put_tail(16'h0010, 16'h0003);
        send_packet(0);

        // early ends: on header byte 11, inside the header, on a length byte
        // after a label, inside a label, inside the tail, a lone byte
        put_header(16'h0007, 8'h00, 8'h00, 16'd1); send_packet(0);
        put_header(16'h0008, 8'h00, 8'h00, 16'd1); send_packet(5);
        put_header(16'h0009, 8'h00, 8'h00, 16'd1);
        put_label(2); put(8'd4);
        send_packet(0);
        put_header(16'h000A, 8'h00, 8'h00, 16'd1);
        put_label(5);
        send_packet(15);
        put_header(16'h000B, 8'h00, 8'h00, 16'd1);
        put(8'h00); put_tail(16'h0001, 16'h0001);
        send_packet(15);
        put(8'h00); send_packet(0);

        wait_drained();

        // ---------------- random part ----------------
        pkt_no = 0;
        while (bytes_sent < BYTE_BUDGET) begin
            // long receiver hold-off while the sender keeps offering
            if (pkt_no == 0) hold_cycles = 150;
            // sender pause until the block has drained
            if (pkt_no == 2) wait_drained();
            build_random_packet();
            keep = ($urandom_range(0, 99) < 12) ? $urandom_range(1, pkt.size()) : 0;
            send_packet(keep);
            pkt_no++;
        end
        steady = 1'b0;

        // drain, then keep clocking for anything stray
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (predictor.failures == 0 && predictor.expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/dnsqp_pkg.sv
src/dnsqp_channels.sv
src/dnsqp_parser.sv
src/dnsqp_result_fifo.sv
src/dns_query_header_name_parser_top.sv
dv/dnsqp_tb_pkg.sv
dv/tb.sv
